// File: design/dnsenc_pkg.sv
`timescale 1ns / 1ps

package dnsenc_pkg;

    // Label limits and sizing
    localparam int LABEL_MAX   = 62;
    localparam int STORE_DEPTH = 62;
    localparam int CNT_W       = 6;

    // Input codes
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic       MODE_END = 1'b1;

    // Input request payload
    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
    } in_t;

    // Result request payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       overflow;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store;      // buffer the input character or flag overflow
        logic len_load;   // load length byte into the output register
        logic char_load;  // load read data into the output register
        logic zero_load;  // load terminating zero into the output register
        logic last;       // last_of_run for the loaded result
        logic rd_en;      // issue a label memory read
        logic rd_first;   // read address 0, else index + 1
        logic clr_count;  // empty the label buffer
        logic clr_ovf;    // clear the sticky overflow flag
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_end;
        logic is_dot;
        logic count_zero;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

// File: design/dnsenc_ctrl.sv
`timescale 1ns / 1ps

module dnsenc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dnsenc_pkg::sts_t  sts,
    output dnsenc_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       end_reg, end_next;

    // Hold state and end-of-name marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
        end
    end

    // Sequence one request: buffer, or flush length, characters and zero
    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.is_end) begin
                        end_next   = 1'b1;
                        state_next = sts.count_zero ? ST_ZERO : ST_LEN;
                    end else if (sts.is_dot) begin
                        end_next   = 1'b0;
                        state_next = ST_LEN;
                    end else begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                if (sts.out_free) begin
                    cmd.len_load = 1'b1;
                    cmd.last     = sts.count_zero && !end_reg;
                    if (sts.count_zero) begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_first = 1'b1;
                        state_next   = ST_SEND;
                    end
                end
            end
            ST_SEND: begin
                if (sts.out_free) begin
                    cmd.char_load = 1'b1;
                    cmd.last      = sts.idx_last && !end_reg;
                    if (sts.idx_last) begin
                        cmd.clr_count = 1'b1;
                        state_next    = end_reg ? ST_ZERO : ST_IDLE;
                    end else begin
                        cmd.rd_en = 1'b1;
                    end
                end
            end
            ST_ZERO: begin
                if (sts.out_free) begin
                    cmd.zero_load = 1'b1;
                    cmd.last      = 1'b1;
                    cmd.clr_ovf   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/dnsenc_dp.sv
`timescale 1ns / 1ps

module dnsenc_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  dnsenc_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dnsenc_pkg::out_t  m_data,
    input  dnsenc_pkg::cmd_t  cmd,
    output dnsenc_pkg::sts_t  sts
);

    localparam int AW = dnsenc_pkg::CNT_W;

    logic [7:0]    label_mem [dnsenc_pkg::STORE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;
    dnsenc_pkg::out_t m_data_reg, m_data_next;
    logic          room;
    logic          load;

    assign room = count_reg < AW'(dnsenc_pkg::LABEL_MAX);
    assign load = cmd.len_load || cmd.char_load || cmd.zero_load;

    // Status to the controller
    assign sts.is_end     = s_data.mode == dnsenc_pkg::MODE_END;
    assign sts.is_dot     = s_data.char_code == dnsenc_pkg::DOT_CHAR;
    assign sts.count_zero = count_reg == '0;
    assign sts.idx_last   = idx_reg == AW'(count_reg - 1'b1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign rd_addr = cmd.rd_first ? '0 : AW'(idx_reg + 1'b1);

    // Write buffered characters; read one a cycle, hold data while stalled
    always_ff @(posedge aclk) begin
        if (cmd.store && room) begin
            label_mem[count_reg] <= s_data.char_code;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= label_mem[rd_addr];
        end
    end

    // Advance count, read index, overflow flag and output register
    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.store) begin
            if (room) begin
                count_next = AW'(count_reg + 1'b1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.clr_count) begin
            count_next = '0;
        end
        if (cmd.len_load) begin
            idx_next = '0;
        end else if (cmd.char_load) begin
            idx_next = AW'(idx_reg + 1'b1);
        end
        if (cmd.clr_ovf) begin
            ovf_next = 1'b0;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next            = 1'b1;
            m_data_next.last_of_run = cmd.last;
            m_data_next.overflow    = ovf_reg;
            if (cmd.len_load) begin
                m_data_next.out_byte = 8'(count_reg);
            end else if (cmd.char_load) begin
                m_data_next.out_byte = rd_data_reg;
            end else begin
                m_data_next.out_byte = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload register needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/dns_name_label_encoder.sv
`timescale 1ns / 1ps

// Encodes a dotted host name, one character per request, into DNS wire
// labels. An ordinary character is buffered and produces no result; up to
// 62 characters per label are kept, further ones are dropped and set the
// sticky overflow bit, which clears after the terminating zero of each
// name. A dot is accepted, then the length byte and each buffered character
// are sent in order; an end request flushes any buffered label and adds the
// zero byte. The label buffer is a memory with one registered read port,
// and that port sets the pace of one result byte per cycle while the output
// is not stalled. A new request is taken only once the previous label flush
// has been handed to the output register, which lets the final result wait
// for m_ready while input is accepted.
module dns_name_label_encoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dnsenc_pkg::in_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dnsenc_pkg::out_t  m_data
);

    dnsenc_pkg::cmd_t cmd;
    dnsenc_pkg::sts_t sts;

    dnsenc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dnsenc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// File: design/dnsenc_chk.sv
`timescale 1ns / 1ps

module dnsenc_chk (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input dnsenc_pkg::in_t  s_data,
    input logic             m_valid,
    input logic             m_ready,
    input dnsenc_pkg::out_t m_data
);

    logic flush_req;
    logic char_req;

    assign flush_req = s_valid && s_ready &&
                       (s_data.mode == dnsenc_pkg::MODE_END ||
                        s_data.char_code == dnsenc_pkg::DOT_CHAR);
    assign char_req  = s_valid && s_ready &&
                       s_data.mode != dnsenc_pkg::MODE_END &&
                       s_data.char_code != dnsenc_pkg::DOT_CHAR;

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Dot or end request starts a flush and blocks input
    a_flush_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_req |=> !s_ready)
        else $error("input taken during a label flush");

    // Ordinary character keeps the input open
    a_char_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        char_req |=> s_ready)
        else $error("ordinary character stalled the input");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind dns_name_label_encoder dnsenc_chk u_dnsenc_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
